// ----- rtl/core/wsfp_pkg.sv -----
// package for the wheel speed frame parser
// frame layout constants, byte positions and the frame struct shared by the core modules
package wsfp_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosWidth   = 4;

  localparam logic [7:0]  HeaderByte       = 8'h5C;
  localparam logic [3:0]  NibbleAll        = 4'hF;
  localparam logic [7:0]  CountMax         = 8'hFF;
  localparam logic [15:0] DefaultThreshold = 16'd800;

  localparam logic [PosWidth-1:0] PosHeader  = PosWidth'(0);
  localparam logic [PosWidth-1:0] PosStatus  = PosWidth'(1);
  localparam logic [PosWidth-1:0] PosLeftHi  = PosWidth'(2);
  localparam logic [PosWidth-1:0] PosLeftLo  = PosWidth'(3);
  localparam logic [PosWidth-1:0] PosRightHi = PosWidth'(4);
  localparam logic [PosWidth-1:0] PosRightLo = PosWidth'(5);
  localparam logic [PosWidth-1:0] PosCheck   = PosWidth'(6);
  localparam logic [PosWidth-1:0] PosLast    = PosWidth'(FrameBytes - 1);

  typedef struct packed {
    logic        ack_ok;
    logic        ack_flag;
    logic        sum_ok;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] mean_speed;
  } frame_t;

endpackage

// ----- rtl/core/wsfp_if.sv -----
// handshake interfaces for received bytes and parsed frame results
// depends on nothing
interface wsfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfp_res_if;
  logic        valid;
  logic        ready;
  logic        frame_status;
  logic        ack_ok;
  logic        ack_flag;
  logic [15:0] left_speed;
  logic [15:0] right_speed;
  logic [15:0] mean_speed;
  logic        speed_drop;
  logic [7:0]  drop_count;

  modport source (
    output valid, output frame_status, output ack_ok, output ack_flag,
    output left_speed, output right_speed, output mean_speed,
    output speed_drop, output drop_count, input ready
  );
  modport sink (
    input valid, input frame_status, input ack_ok, input ack_flag,
    input left_speed, input right_speed, input mean_speed,
    input speed_drop, input drop_count, output ready
  );
endinterface

// ----- rtl/core/wsfp_collect.sv -----
// byte collector: header hunt, frame assembly, checksum and mean, frame register
// depends on wsfp_pkg and wsfp_rx_if
module wsfp_collect import wsfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsfp_rx_if.sink       rx_i,
  output logic          frm_valid_o,
  input  logic          frm_ready_i,
  output frame_t        frm_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          stat_q, stat_d;
  logic [15:0]         left_q, left_d;
  logic [15:0]         right_q, right_d;
  logic [7:0]          sum_q, sum_d;
  logic                frm_valid_q, frm_valid_d;
  frame_t              frm_q, frm_d;
  logic                accept;
  logic [16:0]         lr_sum;
  logic [16:0]         lr_adj;

  assign rx_i.ready = !frm_valid_q || frm_ready_i;
  assign accept     = rx_i.valid && rx_i.ready;

  assign lr_sum = {left_q[15], left_q} + {right_q[15], right_q};
  assign lr_adj = lr_sum + {16'b0, lr_sum[16]};

  always_comb begin
    pos_d       = pos_q;
    stat_d      = stat_q;
    left_d      = left_q;
    right_d     = right_q;
    sum_d       = sum_q;
    frm_valid_d = frm_ready_i ? 1'b0 : frm_valid_q;
    frm_d       = frm_q;
    if (accept) begin
      case (pos_q)
        PosHeader: ;
        PosStatus: begin
          stat_d = rx_i.rx_byte;
          sum_d  = '0;
        end
        PosLeftHi: begin
          left_d[15:8] = rx_i.rx_byte;
          sum_d        = sum_q + rx_i.rx_byte;
        end
        PosLeftLo: begin
          left_d[7:0] = rx_i.rx_byte;
          sum_d       = sum_q + rx_i.rx_byte;
        end
        PosRightHi: begin
          right_d[15:8] = rx_i.rx_byte;
          sum_d         = sum_q + rx_i.rx_byte;
        end
        PosRightLo: begin
          right_d[7:0] = rx_i.rx_byte;
          sum_d        = sum_q + rx_i.rx_byte;
        end
        PosCheck: begin
          frm_valid_d       = 1'b1;
          frm_d.ack_ok      = (stat_q[7:4] == NibbleAll);
          frm_d.ack_flag    = (stat_q[3:0] == NibbleAll);
          frm_d.sum_ok      = (sum_q == rx_i.rx_byte);
          frm_d.left_speed  = left_q;
          frm_d.right_speed = right_q;
          frm_d.mean_speed  = lr_adj[16:1];
        end
        default: ;
      endcase
      if (pos_q == PosHeader) begin
        if (rx_i.rx_byte == HeaderByte) begin
          pos_d = PosStatus;
        end
      end else if (pos_q >= PosCheck && pos_q >= PosLast) begin
        pos_d = PosHeader;
      end else begin
        pos_d = pos_q + PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosHeader;
      frm_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q  <= stat_d;
    left_q  <= left_d;
    right_q <= right_d;
    sum_q   <= sum_d;
    frm_q   <= frm_d;
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

// ----- rtl/core/wsfp_track.sv -----
// drop tracker: threshold register, previous mean, drop counter and result register
// depends on wsfp_pkg and wsfp_res_if
module wsfp_track import wsfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          frm_valid_i,
  output logic          frm_ready_o,
  input  frame_t        frm_i,
  wsfp_res_if.source    res_o
);

  logic [15:0] thr_q, thr_d;
  logic [15:0] prev_q, prev_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        res_valid_q, res_valid_d;
  logic        status_q, status_d;
  logic        ack_ok_q, ack_ok_d;
  logic        ack_flag_q, ack_flag_d;
  logic [15:0] left_q, left_d;
  logic [15:0] right_q, right_d;
  logic [15:0] mean_q, mean_d;
  logic        drop_q, drop_d;
  logic [7:0]  count_q, count_d;
  logic        take;
  logic [17:0] diff;
  logic        drop;

  assign frm_ready_o = !res_valid_q || res_o.ready;
  assign take        = frm_valid_i && frm_ready_o;

  assign diff = {prev_q[15], prev_q[15], prev_q}
              - {frm_i.mean_speed[15], frm_i.mean_speed[15], frm_i.mean_speed};
  assign drop = $signed(diff) > $signed({2'b00, thr_q});

  always_comb begin
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    res_valid_d = res_o.ready ? 1'b0 : res_valid_q;
    status_d    = status_q;
    ack_ok_d    = ack_ok_q;
    ack_flag_d  = ack_flag_q;
    left_d      = left_q;
    right_d     = right_q;
    mean_d      = mean_q;
    drop_d      = drop_q;
    count_d     = count_q;
    if (take) begin
      res_valid_d = 1'b1;
      ack_ok_d    = frm_i.ack_ok;
      ack_flag_d  = frm_i.ack_flag;
      if (frm_i.sum_ok) begin
        if (drop) begin
          cnt_d = (cnt_q == CountMax) ? cnt_q : cnt_q + 8'd1;
        end else begin
          cnt_d = '0;
        end
        prev_d   = frm_i.mean_speed;
        status_d = 1'b0;
        left_d   = frm_i.left_speed;
        right_d  = frm_i.right_speed;
        mean_d   = frm_i.mean_speed;
        drop_d   = drop;
        count_d  = cnt_d;
      end else begin
        status_d = 1'b1;
        left_d   = '0;
        right_d  = '0;
        mean_d   = '0;
        drop_d   = 1'b0;
        count_d  = cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= DefaultThreshold;
      prev_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    ack_ok_q   <= ack_ok_d;
    ack_flag_q <= ack_flag_d;
    left_q     <= left_d;
    right_q    <= right_d;
    mean_q     <= mean_d;
    drop_q     <= drop_d;
    count_q    <= count_d;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.frame_status = status_q;
  assign res_o.ack_ok       = ack_ok_q;
  assign res_o.ack_flag     = ack_flag_q;
  assign res_o.left_speed   = left_q;
  assign res_o.right_speed  = right_q;
  assign res_o.mean_speed   = mean_q;
  assign res_o.speed_drop   = drop_q;
  assign res_o.drop_count   = count_q;

endmodule

// ----- rtl/core/wheel_speed_frame_parser.sv -----
// wheel speed frame parser top level: byte collector feeding the drop tracker
// depends on wsfp_pkg, wsfp_rx_if, wsfp_res_if, wsfp_collect and wsfp_track
// takes one byte per cycle unless a full frame register holds back the byte input; the
// checksum byte's transaction loads the frame register, which passes to the result register once taken
// a stalled result holds the frame register, which then holds back the byte input
// reset clears position, drop counter and previous mean and loads a threshold of 800
module wheel_speed_frame_parser import wsfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  wsfp_rx_if.sink     rx_i,
  wsfp_res_if.source  res_o
);

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  wsfp_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  wsfp_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .res_o       (res_o)
  );

  a_frame_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid && frm_ready |=> res_o.valid)
    else $error("frame transaction did not load the result register");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_status |->
      res_o.left_speed == '0 && res_o.right_speed == '0 &&
      res_o.mean_speed == '0 && !res_o.speed_drop)
    else $error("checksum failure carries nonzero fields");

  a_drop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.speed_drop |-> res_o.drop_count != '0)
    else $error("speed drop with zero drop count");

  a_nodrop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.frame_status && !res_o.speed_drop |-> res_o.drop_count == '0)
    else $error("good frame without drop kept a drop count");

endmodule
